// ===== design/pcmsp_pkg.sv =====
// Package for the PCM sample player channel: widths, codes, reset values,
// the state encoding and the level scaling function.
// No dependencies; imported by every module of the block.
package pcmsp_pkg;

    localparam int SAMPLE_DEPTH = 65536;
    localparam int ADDR_W       = $clog2(SAMPLE_DEPTH);
    localparam int MAX_PER_TICK = 64;
    localparam int CNT_W        = $clog2(MAX_PER_TICK + 1);

    localparam int ACC_W        = 26;
    localparam int POS_W        = 17;
    localparam int STEP_W       = 24;
    localparam int RATE_W       = 20;
    localparam int VOL_W        = 7;
    localparam int LEN_W        = 17;
    localparam int SMP_W        = 8;
    localparam int CMD_W        = 2;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 24;

    localparam logic [RATE_W-1:0] OUT_RATE_RST = RATE_W'(125000);
    localparam logic [VOL_W-1:0]  VOLUME_RST   = VOL_W'(127);

    localparam logic signed [15:0] LEVEL_MIN = -16'sd128;
    localparam logic signed [15:0] LEVEL_MAX = 16'sd127;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK   = 2'd0,
        CMD_LOAD   = 2'd1,
        CMD_START  = 2'd2,
        CMD_SETPOS = 2'd3
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STEP_FREQ   = 3'd0,
        CFG_OUT_RATE    = 3'd1,
        CFG_VOLUME      = 3'd2,
        CFG_SAMPLE_LEN  = 3'd3,
        CFG_LOOP_START  = 3'd4,
        CFG_LOOP_END    = 3'd5,
        CFG_LOOP_ENABLE = 3'd6,
        CFG_MUTE        = 3'd7
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_EMIT
    } state_t;

    // Write request into the sample memory.
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [SMP_W-1:0]  data;
    } mem_wr_t;

    // Scales a signed sample by the volume, floors by 128 and clamps.
    function automatic logic signed [SMP_W-1:0] scale_level(
        input logic signed [SMP_W-1:0] raw,
        input logic [VOL_W-1:0]        vol
    );
        logic signed [15:0] prod;
        logic signed [15:0] shifted;
        logic signed [SMP_W-1:0] res;
        prod    = 16'(raw * $signed({1'b0, vol}));
        shifted = prod >>> 7;
        if (shifted < LEVEL_MIN) begin
            res = SMP_W'(LEVEL_MIN);
        end
        else if (shifted > LEVEL_MAX) begin
            res = SMP_W'(LEVEL_MAX);
        end
        else begin
            res = SMP_W'(shifted);
        end
        return res;
    endfunction

endpackage

// ===== design/pcm_sample_player_channel_unit.sv =====
// PCM sample player channel: load, start, seek and tick requests; ticks emit levels.
// A tick request's first level passes the FETCH and EMIT states and is then registered.
// Each level takes one sample memory read (FETCH), then scale and emit (EMIT);
// a tick holds off requests until its last level is emitted; other requests do not.
// Reset (rst_n, asynchronous, active low) clears control state and loads register
// defaults; the sample memory keeps no reset and needs no clearing pass.
module pcm_sample_player_channel_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    // request channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [pcmsp_pkg::CMD_W-1:0]         cmd,
    input  logic [pcmsp_pkg::ADDR_W-1:0]        address,
    input  logic signed [pcmsp_pkg::SMP_W-1:0]  data,
    // level channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [pcmsp_pkg::SMP_W-1:0]  level,
    output logic                                last_of_tick,
    output logic                                still_playing,
    // configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pcmsp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pcmsp_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import pcmsp_pkg::*;

    // Configuration registers.
    logic [STEP_W-1:0] step_freq_reg;
    logic [RATE_W-1:0] out_rate_reg;
    logic [VOL_W-1:0]  volume_reg;
    logic [LEN_W-1:0]  sample_len_reg;
    logic [ADDR_W-1:0] loop_start_reg;
    logic [LEN_W-1:0]  loop_end_reg;
    logic              loop_enable_reg;
    logic              mute_reg;

    // Playback state.
    state_t             state_reg, state_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic               playing_reg, playing_next;
    logic [ADDR_W-1:0]  pend_pos_reg, pend_pos_next;
    logic               pend_flag_reg, pend_flag_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;

    // Output register.
    logic               out_valid_reg, out_valid_next;
    logic [SMP_W-1:0]   level_reg, level_next;
    logic               last_reg, last_next;
    logic               still_reg, still_next;

    // Sample memory interface.
    mem_wr_t            mem_wr;
    logic [SMP_W-1:0]   mem_rd_data;

    // Datapath terms.
    logic               in_accept;
    logic               slot_free;
    logic [ACC_W:0]     acc_sub;
    logic [ACC_W-1:0]   acc_sub_sat;
    logic [ACC_W-1:0]   acc_add;
    logic [POS_W-1:0]   pos_inc;
    logic               in_range;
    logic [SMP_W-1:0]   scaled;

    // Configuration writes must be issued only while the channel is quiet;
    // the block does not enforce this, and the port is always open.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            step_freq_reg   <= '0;
            out_rate_reg    <= OUT_RATE_RST;
            volume_reg      <= VOLUME_RST;
            sample_len_reg  <= '0;
            loop_start_reg  <= '0;
            loop_end_reg    <= '0;
            loop_enable_reg <= 1'b0;
            mute_reg        <= 1'b0;
        end
        else if (cfg_valid && cfg_ready) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_STEP_FREQ:   step_freq_reg   <= cfg_data[STEP_W-1:0];
                CFG_OUT_RATE:    out_rate_reg    <= cfg_data[RATE_W-1:0];
                CFG_VOLUME:      volume_reg      <= cfg_data[VOL_W-1:0];
                CFG_SAMPLE_LEN:  sample_len_reg  <= cfg_data[LEN_W-1:0];
                CFG_LOOP_START:  loop_start_reg  <= cfg_data[ADDR_W-1:0];
                CFG_LOOP_END:    loop_end_reg    <= cfg_data[LEN_W-1:0];
                CFG_LOOP_ENABLE: loop_enable_reg <= cfg_data[0];
                CFG_MUTE:        mute_reg        <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    // Requests are taken only while the sequencer is idle.
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;

    // Load requests go straight into the sample memory.
    assign mem_wr.en   = in_accept && (cmd_t'(cmd) == CMD_LOAD);
    assign mem_wr.addr = address;
    assign mem_wr.data = data;

    pcmsp_sample_mem u_sample_mem (
        .clk     (clk),
        .wr      (mem_wr),
        .rd_addr (pos_reg[ADDR_W-1:0]),
        .rd_data (mem_rd_data)
    );

    // The output register can take a new level when it is empty or being drained.
    assign slot_free = !out_valid_reg || !out_stall;

    // Tick subtraction saturates at the most negative accumulator value. The
    // difference lies between -2^26 and 2^25, so a wrap past -2^25 shows as a
    // sign bit that disagrees with the next bit.
    assign acc_sub = {acc_reg[ACC_W-1], acc_reg} - {{(ACC_W+1-STEP_W){1'b0}}, step_freq_reg};
    assign acc_sub_sat = (acc_sub[ACC_W] && !acc_sub[ACC_W-1])
                       ? {1'b1, {(ACC_W-1){1'b0}}}
                       : acc_sub[ACC_W-1:0];

    // Adding the output rate back: the accumulator is negative here, so the sum
    // stays below the rate and cannot overflow.
    assign acc_add = acc_reg + {{(ACC_W-RATE_W){1'b0}}, out_rate_reg};
    assign pos_inc = pos_reg + POS_W'(1);

    // A position at or beyond the sample length or the memory plays silence.
    assign in_range = (pos_reg < sample_len_reg) && (pos_reg < POS_W'(SAMPLE_DEPTH));
    assign scaled   = scale_level(mem_rd_data, volume_reg);

    always_comb
    begin
        state_next     = state_reg;
        acc_next       = acc_reg;
        pos_next       = pos_reg;
        playing_next   = playing_reg;
        pend_pos_next  = pend_pos_reg;
        pend_flag_next = pend_flag_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && out_stall;
        level_next     = level_reg;
        last_next      = last_reg;
        still_next     = still_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept) begin
                    unique case (cmd_t'(cmd))
                        CMD_TICK:
                        begin
                            // A stopped channel ignores ticks and keeps its
                            // accumulator.
                            if (playing_reg) begin
                                acc_next = acc_sub_sat;
                                cnt_next = '0;
                                if (acc_sub_sat[ACC_W-1]) begin
                                    state_next = ST_FETCH;
                                end
                            end
                        end
                        CMD_LOAD:
                        begin
                        end
                        CMD_START:
                        begin
                            acc_next     = '0;
                            playing_next = 1'b1;
                            if (pend_flag_reg) begin
                                pos_next       = {1'b0, pend_pos_reg};
                                pend_flag_next = 1'b0;
                            end
                            else begin
                                pos_next = '0;
                            end
                        end
                        CMD_SETPOS:
                        begin
                            pos_next       = {1'b0, address};
                            pend_pos_next  = address;
                            pend_flag_next = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_FETCH:
            begin
                // The memory read at the current position completes this cycle.
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (slot_free) begin
                    acc_next       = acc_add;
                    cnt_next       = cnt_reg + CNT_W'(1);
                    out_valid_next = 1'b1;
                    level_next     = (!mute_reg && in_range) ? scaled : '0;
                    if (loop_enable_reg && (pos_inc >= loop_end_reg)) begin
                        pos_next = {1'b0, loop_start_reg};
                    end
                    else begin
                        pos_next = pos_inc;
                        if (pos_inc >= sample_len_reg) begin
                            playing_next = 1'b0;
                        end
                    end
                    still_next = playing_next;
                    // The tick ends once the accumulator recovers, the level
                    // cap is reached or playback stops.
                    last_next  = !acc_add[ACC_W-1]
                              || (cnt_reg == CNT_W'(MAX_PER_TICK - 1))
                              || !playing_next;
                    state_next = last_next ? ST_IDLE : ST_FETCH;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            acc_reg       <= '0;
            pos_reg       <= '0;
            playing_reg   <= 1'b0;
            pend_pos_reg  <= '0;
            pend_flag_reg <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            pos_reg       <= pos_next;
            playing_reg   <= playing_next;
            pend_pos_reg  <= pend_pos_next;
            pend_flag_reg <= pend_flag_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Level payload needs no reset.
    always_ff @(posedge clk)
    begin
        level_reg <= level_next;
        last_reg  <= last_next;
        still_reg <= still_next;
    end

    assign out_valid     = out_valid_reg;
    assign level         = level_reg;
    assign last_of_tick  = last_reg;
    assign still_playing = still_reg;

endmodule

// ===== design/pcmsp_sample_mem.sv =====
// Sample memory of the PCM sample player channel: one write port and one
// registered read port. Depends on pcmsp_pkg.
module pcmsp_sample_mem (
    input  logic                            clk,
    input  pcmsp_pkg::mem_wr_t              wr,
    input  logic [pcmsp_pkg::ADDR_W-1:0]    rd_addr,
    output logic [pcmsp_pkg::SMP_W-1:0]     rd_data
);
    import pcmsp_pkg::*;

    logic [SMP_W-1:0] mem [SAMPLE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
    end

    // The address is read every cycle; the sequencer holds it steady.
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== design/pcmsp_checker.sv =====
// Port-level checks for the PCM sample player channel, bound to the top level.
// Depends on pcmsp_pkg and pcm_sample_player_channel_unit.
module pcmsp_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_stall,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic signed [pcmsp_pkg::SMP_W-1:0]  level,
    input  logic                                last_of_tick,
    input  logic                                still_playing
);
    import pcmsp_pkg::*;

    // A stalled level stays offered and unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(level)
            && $stable(last_of_tick) && $stable(still_playing))
    else $error("stalled level changed or was dropped");

    // While a level that is not the last of its tick waits, the tick is still
    // running and no new request may be taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_of_tick |-> in_stall)
    else $error("request channel open in the middle of a tick");

    // The level that stops playback always closes its tick.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !still_playing |-> last_of_tick)
    else $error("playback stopped without ending the tick");

    // A level that is held back and is not the last one keeps the tick from
    // finishing, so the request channel stays closed in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall && !last_of_tick |=> in_stall)
    else $error("tick ended without a final level");

endmodule

bind pcm_sample_player_channel_unit pcmsp_checker u_pcmsp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .level         (level),
    .last_of_tick  (last_of_tick),
    .still_playing (still_playing)
);

// ===== tb/sv/pcm_sample_player_channel_unit_test.sv =====
// Self-checking testbench for the PCM sample player channel unit.
// It predicts every emitted level from its own channel model and drives random idling on both
// sides. Depends only on pcmsp_pkg and the pcm_sample_player_channel_unit RTL.
`timescale 1ns / 1ps

module pcm_sample_player_channel_unit_test;

    import pcmsp_pkg::*;

    // Run shape. TOTAL_ITEMS bounds the requests of the whole run, sample loads included;
    // the random phases stop once it is reached.
    localparam int TOTAL_ITEMS   = 410;
    localparam int SETTLE_CYCLES = 10;
    localparam int DRAIN_CYCLES  = 20;
    localparam int HOLD_CYCLES   = 400;
    localparam int SHOW_LIMIT    = 10;
    // The longest correct quiet stretch is the long level hold-off plus a settle pause and a
    // long sender gap. The limit takes that several times over.
    localparam int STALL_LIMIT   = 4000;
    localparam int ACC_FLOOR     = -(1 << 25);

    // Channel state and register copies that the predictor keeps.
    typedef struct {
        int                acc;
        logic [POS_W-1:0]  pos;
        logic              playing;
        logic [ADDR_W-1:0] pend_pos;
        logic              pend;
    } chan_state_t;

    typedef struct {
        logic [STEP_W-1:0] step;
        logic [RATE_W-1:0] rate;
        logic [VOL_W-1:0]  vol;
        logic [LEN_W-1:0]  len;
        logic [ADDR_W-1:0] lstart;
        logic [POS_W-1:0]  lend;
        logic              loop_en;
        logic              mute;
    } chan_regs_t;

    typedef struct packed {
        logic signed [SMP_W-1:0] level;
        logic                    last;
        logic                    playing;
    } level_t;

    logic                     clk;
    logic                     rst_n     = 1'b0;
    logic                     in_valid  = 1'b0;
    logic                     in_stall;
    logic [CMD_W-1:0]         cmd       = '0;
    logic [ADDR_W-1:0]        address   = '0;
    logic signed [SMP_W-1:0]  data      = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic signed [SMP_W-1:0]  level;
    logic                     last_of_tick;
    logic                     still_playing;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index = '0;
    logic [CFG_DATA_W-1:0]    cfg_data  = '0;

    chan_state_t chan = '{0, '0, 1'b0, '0, 1'b0};
    chan_regs_t  regs = '{'0, OUT_RATE_RST, VOLUME_RST, '0, '0, '0, 1'b0, 1'b0};

    // Mirror of the sample memory. The loaded flags let the sender avoid ever
    // playing an entry that was never written.
    logic signed [SMP_W-1:0] samples [SAMPLE_DEPTH];
    bit                      loaded  [SAMPLE_DEPTH];

    level_t levels_due[$];     // levels still owed by the block, oldest first
    level_t tick_levels[$];    // levels produced by the most recent predicted request
    int     tick_reads[$];     // sample positions read by the most recent predicted request
    int     level_errors = 0;
    int     items_sent   = 0;  // accepted requests of the whole run

    int src_idle_pct  = 0;     // chance of a gap before each request, in percent
    int sink_busy_pct = 0;     // chance of a stall burst on the level side, in percent
    bit hold_levels   = 1'b0;  // asks the level sink for one long hold-off

    pcm_sample_player_channel_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .cmd           (cmd),
        .address       (address),
        .data          (data),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .level         (level),
        .last_of_tick  (last_of_tick),
        .still_playing (still_playing),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Most gaps are zero. Some are short, and about one in ten of those is long.
    function automatic int pick_gap(int pct);
        if ($urandom_range(99) >= pct) begin
            return 0;
        end
        if ($urandom_range(9) == 0) begin
            return $urandom_range(10, 40);
        end
        return $urandom_range(1, 3);
    endfunction

    // Channel predictor. It applies one accepted request to the channel state. For a tick it
    // leaves the levels that the tick emits in tick_levels and the sample positions that it
    // reads in tick_reads.
    function automatic void apply_request(cmd_t c, logic [ADDR_W-1:0] a,
                                          logic signed [SMP_W-1:0] d);
        int     acc_next;
        int     prod;
        int     n;
        level_t lv;
        tick_levels.delete();
        tick_reads.delete();
        case (c)
            CMD_LOAD: begin
                samples[a] = d;
                loaded[a]  = 1'b1;
            end
            CMD_START: begin
                chan.acc     = 0;
                chan.pos     = chan.pend ? POS_W'(chan.pend_pos) : '0;
                chan.pend    = 1'b0;
                chan.playing = 1'b1;
            end
            CMD_SETPOS: begin
                // A seek moves the position at once and is also kept for the next start.
                chan.pos      = POS_W'(a);
                chan.pend_pos = a;
                chan.pend     = 1'b1;
            end
            default: begin
                // A tick on a stopped channel leaves even the accumulator alone.
                if (chan.playing) begin
                    acc_next = chan.acc - int'(regs.step);
                    if (acc_next < ACC_FLOOR) begin
                        acc_next = ACC_FLOOR;
                    end
                    chan.acc = acc_next;
                    n = 0;
                    while (chan.acc < 0 && n < MAX_PER_TICK && chan.playing) begin
                        chan.acc += int'(regs.rate);
                        lv.level = '0;
                        if (chan.pos < regs.len && chan.pos < SAMPLE_DEPTH) begin
                            tick_reads.insert(tick_reads.size(), int'(chan.pos));
                            if (!regs.mute) begin
                                prod = int'(samples[chan.pos]) * int'(regs.vol);
                                prod = prod >>> 7;
                                if (prod < -128) begin
                                    prod = -128;
                                end
                                if (prod > 127) begin
                                    prod = 127;
                                end
                                lv.level = prod[SMP_W-1:0];
                            end
                        end
                        chan.pos = chan.pos + POS_W'(1);
                        if (regs.loop_en && chan.pos >= regs.lend) begin
                            chan.pos = POS_W'(regs.lstart);
                        end
                        else if (chan.pos >= regs.len) begin
                            chan.playing = 1'b0;
                        end
                        lv.playing = chan.playing;
                        // The tick ends here if the loop condition fails for the next level.
                        lv.last = !(chan.acc < 0 && n < MAX_PER_TICK - 1 && chan.playing);
                        tick_levels.insert(tick_levels.size(), lv);
                        n++;
                    end
                end
            end
        endcase
    endfunction

    // Offers one request after a random gap and waits for the handshake. The valid stays
    // high afterward, so the caller either offers the next request at once or drops valid
    // before it lets time pass.
    task automatic offer_req(cmd_t c, logic [ADDR_W-1:0] a, logic signed [SMP_W-1:0] d);
        int gap;
        gap = pick_gap(src_idle_pct);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= c;
        address  <= a;
        data     <= d;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        items_sent++;
        apply_request(c, a, d);
        foreach (tick_levels[i]) begin
            levels_due.insert(levels_due.size(), tick_levels[i]);
        end
    endtask

    // Sends one request. Before a tick, it runs the tick on a copy of the state. Every sample
    // that the tick would read and that was never loaded gets a load with random data first.
    task automatic send_req(cmd_t c, logic [ADDR_W-1:0] a, logic signed [SMP_W-1:0] d);
        chan_state_t saved;
        int          need[$];
        if (c == CMD_TICK) begin
            saved = chan;
            apply_request(CMD_TICK, '0, '0);
            need = tick_reads;
            chan = saved;
            foreach (need[i]) begin
                if (!loaded[need[i]]) begin
                    offer_req(CMD_LOAD, ADDR_W'(need[i]), SMP_W'($urandom));
                end
            end
        end
        offer_req(c, a, d);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (levels_due.size() != 0) @(posedge clk);
    endtask

    // Writes all eight registers while the channel is quiet. It waits until every owed level is in
    // and then adds a settle pause before the first write.
    task automatic set_regs(chan_regs_t c);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_reg(CFG_STEP_FREQ,   c.step);
        write_reg(CFG_OUT_RATE,    CFG_DATA_W'(c.rate));
        write_reg(CFG_VOLUME,      CFG_DATA_W'(c.vol));
        write_reg(CFG_SAMPLE_LEN,  CFG_DATA_W'(c.len));
        write_reg(CFG_LOOP_START,  CFG_DATA_W'(c.lstart));
        write_reg(CFG_LOOP_END,    CFG_DATA_W'(c.lend));
        write_reg(CFG_LOOP_ENABLE, CFG_DATA_W'(c.loop_en));
        write_reg(CFG_MUTE,        CFG_DATA_W'(c.mute));
        regs = c;
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // This test starts from the reset registers. A tick on a stopped channel emits nothing.
    // The loads go to both ends of memory with both extreme sample values. A start followed
    // by a tick with the default step of zero also emits nothing.
    task automatic test_idle_channel();
        src_idle_pct  = 0;
        sink_busy_pct = 0;
        send_req(CMD_TICK,  16'hFFFF, 8'sh7F);
        send_req(CMD_LOAD,  16'h0000, 8'sh80);
        send_req(CMD_LOAD,  16'hFFFF, 8'sh7F);
        send_req(CMD_START, 16'h0000, 8'sh00);
        send_req(CMD_TICK,  16'h0000, 8'sh00);
    endtask

    // This test checks volume scaling with a floor shift on known samples. Playback ends on
    // the last sample of a four-sample clip. It also covers a zero-length clip and volume zero.
    task automatic test_scaled_levels();
        chan_regs_t c;
        c = '{24'd250, 20'd100, 7'd127, 17'd4, 16'd0, 17'd0, 1'b0, 1'b0};
        set_regs(c);
        send_req(CMD_LOAD, 16'd1, 8'sh7F);
        send_req(CMD_LOAD, 16'd2, 8'shFF);
        send_req(CMD_LOAD, 16'd3, 8'sh41);
        send_req(CMD_START, '0, '0);
        send_req(CMD_TICK, '0, '0);
        send_req(CMD_TICK, '0, '0);
        c.len = 17'd0;
        set_regs(c);
        send_req(CMD_START, '0, '0);
        send_req(CMD_TICK, '0, '0);
        c.len = 17'd4;
        c.vol = 7'd0;
        set_regs(c);
        send_req(CMD_START, '0, '0);
        send_req(CMD_TICK, '0, '0);
    endtask

    // This test covers a pending seek taken by start and a seek during playback, both while
    // muted. A loop end of zero makes every step wrap. A seek far beyond the clip emits a zero
    // level and stops playback, and a later tick emits nothing.
    task automatic test_loop_and_seek();
        chan_regs_t c;
        c = '{24'd700, 20'd100, 7'd127, 17'd8, 16'd2, 17'd6, 1'b1, 1'b1};
        set_regs(c);
        send_req(CMD_SETPOS, 16'd5, '0);
        send_req(CMD_START, '0, '0);
        send_req(CMD_TICK, '0, '0);
        send_req(CMD_SETPOS, 16'd7, '0);
        send_req(CMD_TICK, '0, '0);
        c.mute = 1'b0;
        c.lend = 17'd0;
        set_regs(c);
        send_req(CMD_TICK, '0, '0);
        c.loop_en = 1'b0;
        set_regs(c);
        send_req(CMD_SETPOS, 16'd40000, '0);
        send_req(CMD_TICK, '0, '0);
        send_req(CMD_TICK, '0, '0);
    endtask

    // With an output rate of zero the accumulator never recovers, so every tick hits the
    // per-tick cap. With the largest step, the accumulator saturates at its floor. The largest
    // rate then works it back up within a single tick.
    task automatic test_cap_and_saturation();
        chan_regs_t c;
        c = '{24'hFFFFFF, 20'd0, 7'd127, 17'd8, 16'd0, 17'd8, 1'b1, 1'b0};
        set_regs(c);
        send_req(CMD_START, '0, '0);
        send_req(CMD_TICK, '0, '0);
        send_req(CMD_TICK, '0, '0);
        c.rate = 20'hFFFFF;
        set_regs(c);
        send_req(CMD_TICK, '0, '0);
        send_req(CMD_TICK, '0, '0);
    endtask

    // This test plays at the very top of the sample memory. The position runs past the last
    // address and wraps to the highest loop start. Without looping, the same step stops
    // playback.
    task automatic test_top_of_memory();
        chan_regs_t c;
        c = '{24'd300, 20'd100, 7'd127, 17'd65536, 16'hFFFF, 17'd65536, 1'b1, 1'b0};
        set_regs(c);
        send_req(CMD_SETPOS, 16'hFFFE, '0);
        send_req(CMD_START, '0, '0);
        send_req(CMD_TICK, '0, '0);
        c.loop_en = 1'b0;
        set_regs(c);
        send_req(CMD_SETPOS, 16'hFFFF, '0);
        send_req(CMD_START, '0, '0);
        send_req(CMD_TICK, '0, '0);
    endtask

    // The level sink holds off for a long stretch. Meanwhile the sender keeps offering busy
    // ticks, so the block backs up and stalls its request side.
    task automatic test_level_backpressure();
        chan_regs_t c;
        c = '{24'd4050, 20'd100, 7'd100, 17'd32, 16'd0, 17'd32, 1'b1, 1'b0};
        set_regs(c);
        src_idle_pct  = 0;
        sink_busy_pct = 0;
        send_req(CMD_START, '0, '0);
        hold_levels = 1'b1;
        repeat (20) send_req(CMD_TICK, '0, '0);
    endtask

    // The sender stops until every level is in, then resumes on the same playback.
    task automatic test_sender_pause();
        src_idle_pct  = 20;
        sink_busy_pct = 20;
        repeat (6) send_req(CMD_TICK, '0, '0);
        wait_drained();
        repeat (6) send_req(CMD_TICK, '0, '0);
    endtask

    // Random phases follow. Each phase writes a fresh register set and then plays a well-formed
    // sequence with random content: an optional seek, a start, then mostly ticks. Seeks, loads,
    // restarts and fully random requests are mixed in.
    task automatic test_random_play();
        chan_regs_t       c;
        int               r;
        int               steps;
        int unsigned      step_val;
        logic [ADDR_W-1:0] seek;
        while (items_sent < TOTAL_ITEMS) begin
            r = $urandom_range(9);
            if (r < 7) begin
                c.len = LEN_W'($urandom_range(1, 64));
            end
            else if (r == 7) begin
                c.len = 17'd0;
            end
            else if (r == 8) begin
                c.len = 17'd65536;
            end
            else begin
                c.len = LEN_W'($urandom_range(0, 65536));
            end
            c.lstart = ($urandom_range(4) == 0) ? 16'($urandom)
                     : 16'($urandom_range(0, (c.len == 0) ? 0 : c.len - 1));
            c.lend   = ($urandom_range(4) == 0) ? 17'd65536 : 17'($urandom_range(0, c.len));
            r = $urandom_range(9);
            if (r < 8) begin
                c.rate = RATE_W'($urandom_range(1, 4096));
            end
            else if (r == 8) begin
                c.rate = 20'hFFFFF;
            end
            else begin
                c.rate = RATE_W'($urandom_range(1, 20'hFFFFF));
            end
            if ($urandom_range(99) < 85) begin
                step_val = c.rate * $urandom_range(0, 6) + $urandom_range(0, c.rate);
                c.step   = (step_val > 24'hFFFFFF) ? 24'hFFFFFF : step_val[STEP_W-1:0];
            end
            else begin
                c.step = STEP_W'($urandom);
            end
            r = $urandom_range(5);
            c.vol     = (r == 0) ? 7'd0 : (r == 1) ? 7'd127 : VOL_W'($urandom);
            c.loop_en = 1'($urandom_range(1));
            c.mute    = ($urandom_range(6) == 0);
            set_regs(c);

            // Some phases run with no idling at all on either side.
            r = $urandom_range(2);
            src_idle_pct  = (r == 0) ? 0 : (r == 1) ? 15 : 40;
            r = $urandom_range(2);
            sink_busy_pct = (r == 0) ? 0 : (r == 1) ? 15 : 40;

            if ($urandom_range(3) == 0) begin
                send_req(CMD_SETPOS, ADDR_W'($urandom_range(0, c.len + 4)), SMP_W'($urandom));
            end
            send_req(CMD_START, ADDR_W'($urandom), SMP_W'($urandom));
            steps = $urandom_range(4, 16);
            repeat (steps) begin
                if (items_sent >= TOTAL_ITEMS) begin
                    break;
                end
                r = $urandom_range(99);
                if (r < 80) begin
                    send_req(CMD_TICK, ADDR_W'($urandom), SMP_W'($urandom));
                end
                else if (r < 88) begin
                    seek = ($urandom_range(2) == 0) ? ADDR_W'($urandom)
                         : ADDR_W'($urandom_range(0, c.len + 4));
                    send_req(CMD_SETPOS, seek, SMP_W'($urandom));
                end
                else if (r < 94) begin
                    send_req(CMD_LOAD, ADDR_W'($urandom), SMP_W'($urandom));
                end
                else if (r < 97) begin
                    send_req(CMD_START, ADDR_W'($urandom), SMP_W'($urandom));
                end
                else begin
                    send_req(cmd_t'($urandom_range(3)), ADDR_W'($urandom), SMP_W'($urandom));
                end
            end
        end
    endtask

    // Level sink. It stalls in short random bursts, with an occasional long one. On request
    // it holds off for HOLD_CYCLES in one stretch.
    initial begin : level_sink
        int left;
        left = 0;
        forever begin
            @(posedge clk);
            if (hold_levels) begin
                left        = HOLD_CYCLES;
                hold_levels = 1'b0;
            end
            else if (left > 0) begin
                left--;
            end
            else begin
                left = pick_gap(sink_busy_pct);
            end
            out_stall <= (left > 0);
        end
    end

    // Each accepted level is compared field by field with the oldest one owed.
    always @(posedge clk) begin : check_levels
        level_t want;
        if (rst_n && out_valid && !out_stall) begin
            if (levels_due.size() == 0) begin
                if (level_errors < SHOW_LIMIT) begin
                    $display("unexpected level: level %0d last %0b playing %0b",
                             level, last_of_tick, still_playing);
                end
                level_errors++;
            end
            else begin
                want = levels_due[0];
                levels_due.delete(0);
                if (level !== want.level || last_of_tick !== want.last
                    || still_playing !== want.playing) begin
                    if (level_errors < SHOW_LIMIT) begin
                        $display("level mismatch: expected level %0d last %0b playing %0b, %s",
                                 want.level, want.last, want.playing, "see actual below");
                        $display("                actual   level %0d last %0b playing %0b",
                                 level, last_of_tick, still_playing);
                    end
                    level_errors++;
                end
            end
        end
    end

    // The watchdog ends the run after too many cycles with no handshake on any channel.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall)
                || (cfg_valid && cfg_ready)) begin
                quiet = 0;
            end
            else begin
                quiet++;
            end
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        test_idle_channel();
        test_scaled_levels();
        test_loop_and_seek();
        test_cap_and_saturation();
        test_top_of_memory();
        test_level_backpressure();
        test_sender_pause();
        test_random_play();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (level_errors == 0 && levels_due.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end
        else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== pcm_sample_player_channel_unit.f =====
design/pcmsp_pkg.sv
design/pcmsp_sample_mem.sv
design/pcm_sample_player_channel_unit.sv
design/pcmsp_checker.sv
tb/sv/pcm_sample_player_channel_unit_test.sv
